/* rtl/buddy_block_allocator_defines.svh */
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define BBA_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("buddy allocator check failed");

// property that must hold in the cycle after its trigger
`define BBA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("buddy allocator check failed");

`endif

/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

    localparam int ORD_W = 6;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [24:0] request_size;
        logic [63:0] block_address;
    } t_req;

    typedef struct packed {
        logic [63:0] result_address;
        logic [1:0]  status;
        logic [4:0]  final_order;
    } t_rsp;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PREP,
        S_A_SCAN,
        S_A_POP,
        S_A_SPLIT,
        S_A_SPUSH,
        S_F_CHECK,
        S_F_WALK,
        S_F_NEXT,
        S_F_UNLINK,
        S_F_PUSH,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_START_ALLOC,
        OP_SCAN_STEP,
        OP_POP_READ,
        OP_POP_SET,
        OP_DEC,
        OP_SPUSH,
        OP_FREE_START,
        OP_WALK_START,
        OP_WALK_READ,
        OP_FOUND_READ,
        OP_WALK_NEXT,
        OP_UNLINK,
        OP_PUSH,
        OP_RES_ALLOC,
        OP_RES_ERR,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] code;
    } t_cmd;

    typedef struct packed {
        logic too_big;
        logic is_free;
        logic bad_free;
        logic scan_over;
        logic head_hit;
        logic split_more;
        logic can_merge;
        logic walk_end;
        logic cur_is_buddy;
    } t_stat;

endpackage

/* rtl/bba_datapath.sv */
`timescale 1ns / 1ps

module bba_datapath #(
    parameter int MAX_POOL_ORDER  = 24,
    parameter int MIN_BLOCK_ORDER = 12
) (
    input  logic          i_clk,
    input  bba_pkg::t_cmd i_cmd,
    input  bba_pkg::t_req i_req,
    input  logic [4:0]    i_pool_order,
    input  logic [63:0]   i_pool_base,
    output bba_pkg::t_stat o_stat,
    output bba_pkg::t_rsp o_rsp
);

    localparam int IW = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
    localparam int BW = IW + 1;
    localparam int NB = 1 << IW;
    localparam int HW = $clog2(MAX_POOL_ORDER + 1);
    localparam int OW = bba_pkg::ORD_W;
    localparam logic [BW-1:0] NIL = BW'(NB);
    localparam logic [OW-1:0] MIN_ORD = OW'(MIN_BLOCK_ORDER);
    localparam logic [OW-1:0] MAX_ORD = OW'(MAX_POOL_ORDER);

    logic [BW-1:0] mem [NB];
    logic [BW-1:0] r_rdata;

    logic [BW-1:0] r_heads [MAX_POOL_ORDER+1];

    logic          r_kind;
    logic [OW-1:0] r_ord;
    logic [OW-1:0] r_i;
    logic [63:0]   r_off;
    logic [BW-1:0] r_idx;
    logic [BW-1:0] r_cur;
    logic [BW-1:0] r_prev;
    logic [BW-1:0] r_steps;
    bba_pkg::t_rsp r_res;
    bba_pkg::t_rsp r_out;

    logic [OW-1:0] pool_ord;
    logic [OW-1:0] top;
    logic [OW-1:0] req_ord;
    logic [BW-1:0] head_rd;
    logic [BW-1:0] bit_i;
    logic [BW-1:0] buddy;
    logic [BW-1:0] split_blk;
    logic [63:0]   hi_mask;
    logic [63:0]   lo_mask;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [BW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    // round size up to a power of two, at least one minimum block
    function automatic logic [OW-1:0] ceil_order(input logic [24:0] size);
        logic [OW-1:0] c;
        c = '0;
        for (int j = 0; j < 25; j++) begin
            if (size > (25'(1) << j)) c = OW'(j + 1);
        end
        if (c < MIN_ORD) c = MIN_ORD;
        return c;
    endfunction

    assign pool_ord  = OW'(i_pool_order);
    assign top       = (pool_ord < MIN_ORD) ? MIN_ORD :
                       (pool_ord > MAX_ORD) ? MAX_ORD : pool_ord;
    assign req_ord   = ceil_order(i_req.request_size);
    assign head_rd   = r_heads[r_i[HW-1:0]];
    assign bit_i     = BW'(1) << (r_i - MIN_ORD);
    assign buddy     = r_idx ^ bit_i;
    assign split_blk = r_idx + bit_i;

    always_comb begin
        for (int j = 0; j < 64; j++) begin
            hi_mask[j] = (OW'(j) >= top) || (j >= (1 << OW));
            lo_mask[j] = (j < (1 << OW)) && (OW'(j) < r_ord);
        end
    end

    always_comb begin
        o_stat.too_big      = r_ord > top;
        o_stat.is_free      = r_kind == bba_pkg::KIND_FREE;
        o_stat.bad_free     = (|(r_off & hi_mask)) || (|(r_off & lo_mask));
        o_stat.scan_over    = r_i > top;
        o_stat.head_hit     = head_rd < NIL;
        o_stat.split_more   = r_i > r_ord;
        o_stat.can_merge    = r_i < top;
        o_stat.walk_end     = !(r_cur < NIL) || (r_steps == NIL);
        o_stat.cur_is_buddy = r_cur == buddy;
    end

    // link memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_cur[IW-1:0];
        unique case (i_cmd.op)
            bba_pkg::OP_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = NIL;
            end
            bba_pkg::OP_POP_READ: begin
                mem_re    = 1'b1;
                mem_raddr = head_rd[IW-1:0];
            end
            bba_pkg::OP_SPUSH: begin
                mem_we    = 1'b1;
                mem_waddr = split_blk[IW-1:0];
                mem_wdata = head_rd;
            end
            bba_pkg::OP_WALK_READ, bba_pkg::OP_FOUND_READ: begin
                mem_re = 1'b1;
            end
            bba_pkg::OP_UNLINK: begin
                mem_we    = r_prev != NIL;
                mem_waddr = r_prev[IW-1:0];
                mem_wdata = r_rdata;
            end
            bba_pkg::OP_PUSH: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IW-1:0];
                mem_wdata = head_rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bba_pkg::OP_INIT: begin
                for (int j = 0; j <= MAX_POOL_ORDER; j++) begin
                    r_heads[j] <= NIL;
                end
                r_heads[top[HW-1:0]] <= '0;
            end
            bba_pkg::OP_LOAD: begin
                r_kind <= i_req.kind;
                r_ord  <= req_ord;
                r_off  <= i_req.block_address - i_pool_base;
            end
            bba_pkg::OP_START_ALLOC: r_i <= r_ord;
            bba_pkg::OP_SCAN_STEP:   r_i <= r_i + OW'(1);
            bba_pkg::OP_POP_READ:    r_idx <= head_rd;
            bba_pkg::OP_POP_SET:     r_heads[r_i[HW-1:0]] <= r_rdata;
            bba_pkg::OP_DEC:         r_i <= r_i - OW'(1);
            bba_pkg::OP_SPUSH:       r_heads[r_i[HW-1:0]] <= split_blk;
            bba_pkg::OP_FREE_START: begin
                r_idx <= BW'(r_off[MIN_BLOCK_ORDER +: IW]);
                r_i   <= r_ord;
            end
            bba_pkg::OP_WALK_START: begin
                r_cur   <= head_rd;
                r_prev  <= NIL;
                r_steps <= '0;
            end
            bba_pkg::OP_WALK_READ: begin
                r_prev  <= r_cur;
                r_steps <= r_steps + BW'(1);
            end
            bba_pkg::OP_WALK_NEXT:   r_cur <= r_rdata;
            bba_pkg::OP_UNLINK: begin
                if (r_prev == NIL) begin
                    r_heads[r_i[HW-1:0]] <= r_rdata;
                end
                if (buddy < r_idx) begin
                    r_idx <= buddy;
                end
                r_i <= r_i + OW'(1);
            end
            bba_pkg::OP_PUSH: begin
                r_heads[r_i[HW-1:0]]  <= r_idx;
                r_res.result_address <= '0;
                r_res.status         <= bba_pkg::ST_OK;
                r_res.final_order    <= r_i[4:0];
            end
            bba_pkg::OP_RES_ALLOC: begin
                r_res.result_address <= i_pool_base +
                                        (64'(r_idx[IW-1:0]) << MIN_BLOCK_ORDER);
                r_res.status         <= bba_pkg::ST_OK;
                r_res.final_order    <= r_ord[4:0];
            end
            bba_pkg::OP_RES_ERR: begin
                r_res.result_address <= '0;
                r_res.status         <= i_cmd.code;
                r_res.final_order    <= '0;
            end
            bba_pkg::OP_OUT:         r_out <= r_res;
            default: begin
            end
        endcase
    end

    assign o_rsp = r_out;

endmodule

/* rtl/bba_controller.sv */
`timescale 1ns / 1ps

module bba_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd  o_cmd
);

    bba_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = bba_pkg::OP_NONE;
        o_cmd.code  = bba_pkg::ST_OK;
        o_req_ready = 1'b0;
        n_out_valid = r_out_valid && !i_rsp_ready;
        unique case (r_state)
            bba_pkg::S_INIT: begin
                o_cmd.op = bba_pkg::OP_INIT;
                n_state  = bba_pkg::S_IDLE;
            end
            bba_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = bba_pkg::OP_LOAD;
                    n_state  = bba_pkg::S_PREP;
                end
            end
            bba_pkg::S_PREP: begin
                priority if (i_stat.too_big) begin
                    o_cmd.op   = bba_pkg::OP_RES_ERR;
                    o_cmd.code = bba_pkg::ST_TOO_BIG;
                    n_state    = bba_pkg::S_DONE;
                end else if (!i_stat.is_free) begin
                    o_cmd.op = bba_pkg::OP_START_ALLOC;
                    n_state  = bba_pkg::S_A_SCAN;
                end else if (i_stat.bad_free) begin
                    o_cmd.op   = bba_pkg::OP_RES_ERR;
                    o_cmd.code = bba_pkg::ST_BAD_FREE;
                    n_state    = bba_pkg::S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_FREE_START;
                    n_state  = bba_pkg::S_F_CHECK;
                end
            end
            bba_pkg::S_A_SCAN: begin
                priority if (i_stat.scan_over) begin
                    o_cmd.op   = bba_pkg::OP_RES_ERR;
                    o_cmd.code = bba_pkg::ST_NO_BLOCK;
                    n_state    = bba_pkg::S_DONE;
                end else if (i_stat.head_hit) begin
                    o_cmd.op = bba_pkg::OP_POP_READ;
                    n_state  = bba_pkg::S_A_POP;
                end else begin
                    o_cmd.op = bba_pkg::OP_SCAN_STEP;
                end
            end
            bba_pkg::S_A_POP: begin
                o_cmd.op = bba_pkg::OP_POP_SET;
                n_state  = bba_pkg::S_A_SPLIT;
            end
            bba_pkg::S_A_SPLIT: begin
                if (i_stat.split_more) begin
                    o_cmd.op = bba_pkg::OP_DEC;
                    n_state  = bba_pkg::S_A_SPUSH;
                end else begin
                    o_cmd.op = bba_pkg::OP_RES_ALLOC;
                    n_state  = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_A_SPUSH: begin
                o_cmd.op = bba_pkg::OP_SPUSH;
                n_state  = bba_pkg::S_A_SPLIT;
            end
            bba_pkg::S_F_CHECK: begin
                if (i_stat.can_merge) begin
                    o_cmd.op = bba_pkg::OP_WALK_START;
                    n_state  = bba_pkg::S_F_WALK;
                end else begin
                    n_state = bba_pkg::S_F_PUSH;
                end
            end
            bba_pkg::S_F_WALK: begin
                priority if (i_stat.walk_end) begin
                    n_state = bba_pkg::S_F_PUSH;
                end else if (i_stat.cur_is_buddy) begin
                    o_cmd.op = bba_pkg::OP_FOUND_READ;
                    n_state  = bba_pkg::S_F_UNLINK;
                end else begin
                    o_cmd.op = bba_pkg::OP_WALK_READ;
                    n_state  = bba_pkg::S_F_NEXT;
                end
            end
            bba_pkg::S_F_NEXT: begin
                o_cmd.op = bba_pkg::OP_WALK_NEXT;
                n_state  = bba_pkg::S_F_WALK;
            end
            bba_pkg::S_F_UNLINK: begin
                o_cmd.op = bba_pkg::OP_UNLINK;
                n_state  = bba_pkg::S_F_CHECK;
            end
            bba_pkg::S_F_PUSH: begin
                o_cmd.op = bba_pkg::OP_PUSH;
                n_state  = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE: begin
                // wait for the output slot to drain
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.op    = bba_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_INIT;
            end
        endcase
        if (i_cfg_wr) begin
            n_state = bba_pkg::S_INIT;
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

/* rtl/buddy_block_allocator.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// request   in         i_req_valid / o_req_ready  i_req (kind, request_size, block_address)
// response  out        o_rsp_valid / i_rsp_ready  o_rsp (result_address, status, final_order)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
// one request at a time; a size or address error is reported without a scan, a failed scan as no
// block; alloc pops a block and splits it down, pushing each upper half; free walks the list
// per merge level, unlinks the buddy and merges, then pushes; all through the single link ram
// after reset or any register write the pool re-inits, requests held off
// a finished response sits in the output register; the next request is taken meanwhile
// and its result waits in the result register until the previous response is taken

`include "buddy_block_allocator_defines.svh"

module buddy_block_allocator #(
    parameter int MAX_POOL_ORDER  = 24,
    parameter int MIN_BLOCK_ORDER = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bba_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output bba_pkg::t_rsp o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    logic [4:0]     r_pool_order;
    logic [63:0]    r_pool_base;
    logic           cfg_wr;
    bba_pkg::t_cmd  cmd;
    bba_pkg::t_stat stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_order <= 5'd24;
            r_pool_base  <= '0;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_pool_base <= pwdata;
            end else begin
                r_pool_order <= pwdata[4:0];
            end
        end
    end

    assign prdata = paddr[3] ? r_pool_base : 64'(r_pool_order);

    bba_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bba_datapath #(
        .MAX_POOL_ORDER  (MAX_POOL_ORDER),
        .MIN_BLOCK_ORDER (MIN_BLOCK_ORDER)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_req        (i_req),
        .i_pool_order (r_pool_order),
        .i_pool_base  (r_pool_base),
        .o_stat       (stat),
        .o_rsp        (o_rsp)
    );

    // an accepted request keeps the block busy in the next cycle
    `BBA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready)
    // a register write always forces the re-init cycle
    `BBA_ASSERT_NEXT(a_init_after_cfg, i_clk, i_rst_n, cfg_wr, !o_req_ready)
    // failures carry neither an address nor an order
    `BBA_ASSERT_NOW(a_err_clean, i_clk, i_rst_n, o_rsp_valid && (o_rsp.status != bba_pkg::ST_OK), (o_rsp.result_address == 64'd0) && (o_rsp.final_order == 5'd0))

endmodule
